@@ rtl/olist_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants for the ordered item list core.
// ----------------------------------------------------------------------------
package olist_pkg;

    localparam int CAPACITY = 64;
    localparam int ID_BITS  = 16;
    localparam int OP_BITS  = 3;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int ST_BITS  = 2;

    localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE     = 3'd2;
    localparam logic [OP_BITS-1:0] OP_CONTAINS   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd4;
    localparam logic [OP_BITS-1:0] OP_CLEAR      = 3'd5;

    localparam logic [ST_BITS-1:0] STATUS_OK      = 2'd0;
    localparam logic [ST_BITS-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [ST_BITS-1:0] STATUS_FULL    = 2'd2;
    localparam logic [ST_BITS-1:0] STATUS_MISSING = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0] operation;
        logic [ID_BITS-1:0] item_id;
    } req_t;

    typedef struct packed {
        logic [ID_BITS-1:0]  popped_id;
        logic                found;
        logic [CNT_BITS-1:0] entry_count;
        logic [ST_BITS-1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic               capture;
        logic [ID_BITS-1:0] capture_key;
        logic [ID_BITS-1:0] key;
        logic               shift_right;
        logic               append;
        logic               shift_left_hit;
        logic               shift_left_all;
    } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/olist_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// olist_cell
// One list position: holds an identifier and its compare result.
// ----------------------------------------------------------------------------
module olist_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire olist_pkg::cell_ctl_t         ctl,
    input  wire logic                         occupied,
    input  wire logic                         tail,
    input  wire logic                         hit_in,
    input  wire logic [olist_pkg::ID_BITS-1:0] left_id,
    input  wire logic [olist_pkg::ID_BITS-1:0] right_id,
    output logic [olist_pkg::ID_BITS-1:0]      id,
    output logic                              match
);

    logic [olist_pkg::ID_BITS-1:0] id_reg;
    logic                          match_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift_right)
        begin
            id_reg <= left_id;
        end
        else if (ctl.append && tail)
        begin
            id_reg <= ctl.key;
        end
        else if (ctl.shift_left_all || (ctl.shift_left_hit && (hit_in || match_reg)))
        begin
            id_reg <= right_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            match_reg <= occupied && (id_reg == ctl.capture_key);
        end
    end

    assign id    = id_reg;
    assign match = match_reg;

endmodule
`default_nettype wire

@@ rtl/olist_chain.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// olist_chain
// Row of list cells with neighbor links and the first-match prefix.
// ----------------------------------------------------------------------------
module olist_chain (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire olist_pkg::cell_ctl_t          ctl,
    input  wire logic [olist_pkg::CNT_BITS-1:0] count,
    output logic [olist_pkg::ID_BITS-1:0]       front_id,
    output logic                               any_hit
);

    logic [olist_pkg::ID_BITS-1:0] ids [olist_pkg::CAPACITY];
    logic [olist_pkg::CAPACITY-1:0] cell_hits;
    logic [olist_pkg::CAPACITY:0]   hit_chain;

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < olist_pkg::CAPACITY; i++)
    begin : g_cell
        logic [olist_pkg::ID_BITS-1:0] left_id;
        logic [olist_pkg::ID_BITS-1:0] right_id;

        if (i == 0)
        begin : g_first
            assign left_id = ctl.key;
        end
        else
        begin : g_mid
            assign left_id = ids[i-1];
        end

        if (i == olist_pkg::CAPACITY - 1)
        begin : g_last
            assign right_id = ids[i];
        end
        else
        begin : g_inner
            assign right_id = ids[i+1];
        end

        olist_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .occupied (olist_pkg::CNT_BITS'(i) < count),
            .tail     (olist_pkg::CNT_BITS'(i) == count),
            .hit_in   (hit_chain[i]),
            .left_id  (left_id),
            .right_id (right_id),
            .id       (ids[i]),
            .match    (cell_hits[i])
        );

        assign hit_chain[i+1] = hit_chain[i] | cell_hits[i];
    end

    assign front_id = ids[0];
    assign any_hit  = hit_chain[olist_pkg::CAPACITY];

endmodule
`default_nettype wire

@@ rtl/ordered_item_list_core.sv @@
// A request transfer captures the operation and key and compares the key in the
// cell row; in ST_EXEC the commit shifts or writes the row and loads the response
// register. No new request is taken until that commit.
// A stalled response holds in the output register; the next request is taken
// and compared but commits only once that response transfers.
// Reset empties the list and drops response valid; cell identifiers are not reset.
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_item_list_core
// Bounded ordered list of identifiers built on a row of compare cells.
// ----------------------------------------------------------------------------
module ordered_item_list_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire olist_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output olist_pkg::rsp_t      rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [olist_pkg::CNT_BITS-1:0]    count_reg;
    logic [olist_pkg::CNT_BITS-1:0]    count_next;
    logic [olist_pkg::OP_BITS-1:0]     op_reg;
    logic [olist_pkg::ID_BITS-1:0]     key_reg;
    olist_pkg::rsp_t                   rsp_reg;
    olist_pkg::rsp_t                   rsp_next;
    logic                              rsp_valid_reg;

    olist_pkg::cell_ctl_t              ctl;
    logic [olist_pkg::ID_BITS-1:0]     front_id;
    logic                              any_hit;
    logic                              accept;
    logic                              commit;
    logic                              is_full;
    logic                              is_empty;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign commit    = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign is_full   = (count_reg == olist_pkg::CNT_BITS'(olist_pkg::CAPACITY));
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        ctl.capture        = accept;
        ctl.capture_key    = req.item_id;
        ctl.key            = key_reg;
        ctl.shift_right    = commit && (op_reg == olist_pkg::OP_PUSH_FRONT) && !is_full;
        ctl.append         = commit && (op_reg == olist_pkg::OP_PUSH_BACK) && !is_full;
        ctl.shift_left_hit = commit && (op_reg == olist_pkg::OP_REMOVE) && any_hit;
        ctl.shift_left_all = commit && (op_reg == olist_pkg::OP_POP_FRONT) && !is_empty;
    end

    olist_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .count    (count_reg),
        .front_id (front_id),
        .any_hit  (any_hit)
    );

    always_comb
    begin
        count_next       = count_reg;
        rsp_next         = '0;
        rsp_next.status  = olist_pkg::STATUS_OK;
        case (op_reg)
            olist_pkg::OP_PUSH_FRONT, olist_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    rsp_next.status = olist_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + olist_pkg::CNT_BITS'(1);
                end
            end
            olist_pkg::OP_REMOVE:
            begin
                if (is_empty)
                begin
                    rsp_next.status = olist_pkg::STATUS_EMPTY;
                end
                else if (!any_hit)
                begin
                    rsp_next.status = olist_pkg::STATUS_MISSING;
                end
                else
                begin
                    count_next     = count_reg - olist_pkg::CNT_BITS'(1);
                    rsp_next.found = 1'b1;
                end
            end
            olist_pkg::OP_CONTAINS:
            begin
                if (is_empty)
                begin
                    rsp_next.status = olist_pkg::STATUS_EMPTY;
                end
                else if (!any_hit)
                begin
                    rsp_next.status = olist_pkg::STATUS_MISSING;
                end
                else
                begin
                    rsp_next.found = 1'b1;
                end
            end
            olist_pkg::OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    rsp_next.status = olist_pkg::STATUS_EMPTY;
                end
                else
                begin
                    count_next         = count_reg - olist_pkg::CNT_BITS'(1);
                    rsp_next.popped_id = front_id;
                end
            end
            olist_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.entry_count = count_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.operation;
            key_reg <= req.item_id;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= olist_pkg::CNT_BITS'(olist_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted request did not start execution");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("response raised without execution");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("entry count changed outside commit");

endmodule
`default_nettype wire

@@ tb/sv/olist_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_tb_pkg
// Scoreboard for the ordered item list core. It keeps its own copy of the
// list, works out the response to each request transfer and checks every
// response transfer against the oldest one still due.
// ----------------------------------------------------------------------------
package olist_tb_pkg;

    import olist_pkg::*;

    localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

    class item_list_scoreboard;

        logic [ID_BITS-1:0] held_ids[$];
        rsp_t               rsp_due[$];
        int                 faults;

        function new();
            faults = 0;
        endfunction

        function int pending();
            return rsp_due.size();
        endfunction

        function int held_count();
            return held_ids.size();
        endfunction

        function logic [ID_BITS-1:0] held_key();
            return held_ids[$urandom_range(held_ids.size() - 1)];
        endfunction

        function void fault(string msg);
            faults++;
            if (faults <= 10)
                $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            int   pos;
            int   i;
            e   = '0;
            pos = -1;
            case (r.operation)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (held_ids.size() >= CAPACITY)
                        e.status = STATUS_FULL;
                    else if (r.operation == OP_PUSH_FRONT)
                        held_ids.push_front(r.item_id);
                    else
                        held_ids.push_back(r.item_id);
                end
                OP_REMOVE, OP_CONTAINS:
                begin
                    if (held_ids.size() == 0)
                        e.status = STATUS_EMPTY;
                    else
                    begin
                        for (i = 0; i < held_ids.size() && pos < 0; i++)
                            if (held_ids[i] == r.item_id)
                                pos = i;
                        if (pos < 0)
                            e.status = STATUS_MISSING;
                        else
                        begin
                            e.found = 1'b1;
                            if (r.operation == OP_REMOVE)
                                held_ids.delete(pos);
                        end
                    end
                end
                OP_POP_FRONT:
                begin
                    if (held_ids.size() == 0)
                        e.status = STATUS_EMPTY;
                    else
                        e.popped_id = held_ids.pop_front();
                end
                OP_CLEAR:
                    held_ids.delete();
                default:
                    ;
            endcase
            e.entry_count = CNT_BITS'(held_ids.size());
            rsp_due.push_back(e);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
                fault($sformatf("%s expected %0h got %0h", field, want, got));
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (rsp_due.size() == 0)
            begin
                fault($sformatf("response %0h with nothing due", got));
                return;
            end
            e = rsp_due.pop_front();
            compare_field("popped_id", e.popped_id, got.popped_id);
            compare_field("found", e.found, got.found);
            compare_field("entry_count", e.entry_count, got.entry_count);
            compare_field("status", e.status, got.status);
        endfunction

    endclass

endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ordered_item_list_core. A directed run covers the
// empty, absent-key, duplicate and spare-code cases, then random phases grow
// the list to full, drain it and mix all operations under random idling on
// both channels, ending with a run at full rate.
// ----------------------------------------------------------------------------
module tb;

    import olist_pkg::*;
    import olist_tb_pkg::*;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    item_list_scoreboard board = new();
    bit                  quiet = 1'b0;
    int                  hold_left = 0;

    always #4 clk = ~clk;

    ordered_item_list_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                board.note_request(req);
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp);
        end
    end

    always @(negedge clk)
    begin
        if (quiet)
            rsp_stall <= 1'b0;
        else if (hold_left > 0)
            hold_left--;
        else if (!rsp_stall && $urandom_range(3) == 0)
        begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(14);
        end
        else
        begin
            rsp_stall <= 1'b0;
            hold_left = $urandom_range(40);
        end
    end

    task automatic send_item(input req_t r);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(7) == 0)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic send_op(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id);
        req_t r;
        r.operation = op;
        r.item_id   = id;
        send_item(r);
    endtask

    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [OP_BITS-1:0] pick_op(input int mode);
        int w[7];
        int roll;
        int i;
        logic [OP_BITS-1:0] codes[6];
        codes = '{OP_PUSH_FRONT, OP_PUSH_BACK, OP_REMOVE, OP_CONTAINS, OP_POP_FRONT, OP_CLEAR};
        case (mode)
            MODE_GROW:   w = '{40, 40, 6, 8, 4, 1, 1};
            MODE_SHRINK: w = '{8, 8, 30, 14, 36, 2, 2};
            default:     w = '{20, 20, 18, 18, 18, 3, 3};
        endcase
        roll = $urandom_range(99);
        for (i = 0; i < 6; i++)
        begin
            if (roll < w[i])
                return codes[i];
            roll -= w[i];
        end
        return $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
    endfunction

    task automatic random_phase(input int n, input int mode);
        logic [ID_BITS-1:0] key;
        repeat (n)
        begin
            if (board.held_count() > 0 && $urandom_range(99) < 45)
                key = board.held_key();
            else if ($urandom_range(3) == 0)
                key = ID_BITS'($urandom_range(7));
            else
                key = ID_BITS'($urandom_range(16'hFFFF));
            send_op(pick_op(mode), key);
        end
    endtask

    initial
    begin
        int waited;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        send_op(OP_POP_FRONT, 16'hFFFF);
        send_op(OP_REMOVE, 16'h0000);
        send_op(OP_CONTAINS, 16'hFFFF);
        send_op(OP_CLEAR, 16'h0000);
        send_op(OP_PUSH_FRONT, 16'h0000);
        send_op(OP_PUSH_BACK, 16'hFFFF);
        send_op(OP_PUSH_FRONT, 16'h1234);
        send_op(OP_CONTAINS, 16'hFFFF);
        send_op(OP_CONTAINS, 16'h5555);
        send_op(OP_REMOVE, 16'h5555);
        send_op(OP_PUSH_BACK, 16'h1234);
        send_op(OP_REMOVE, 16'h1234);
        send_op(OP_CONTAINS, 16'h1234);
        send_op(OP_SPARE_LO, 16'hAAAA);
        send_op(OP_SPARE_HI, 16'h5555);
        send_op(OP_POP_FRONT, 16'h00FF);
        send_op(OP_POP_FRONT, 16'h0000);
        send_op(OP_POP_FRONT, 16'hFF00);
        send_op(OP_POP_FRONT, 16'h0000);
        send_op(OP_PUSH_BACK, 16'hABCD);
        send_op(OP_CLEAR, 16'hFFFF);
        send_op(OP_CONTAINS, 16'hABCD);
        settle();

        random_phase(150, MODE_GROW);
        random_phase(150, MODE_SHRINK);
        random_phase(150, MODE_GROW);
        settle();
        repeat (8)
            random_phase($urandom_range(80, 160), $urandom_range(2));
        random_phase(120, MODE_GROW);
        random_phase(120, MODE_SHRINK);

        quiet = 1'b1;
        random_phase(100, MODE_GROW);
        random_phase(80, MODE_MIXED);

        @(negedge clk);
        req_valid <= 1'b0;
        waited = 0;
        while (board.pending() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (board.pending() != 0)
            board.fault($sformatf("%0d responses never arrived", board.pending()));

        if (board.faults == 0)
            $display("ordered_item_list_core verification clean");
        else
            $display("ordered_item_list_core verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("ordered_item_list_core verification failed");
        $finish;
    end

endmodule

@@ ordered_item_list_core.f @@
rtl/olist_pkg.sv
rtl/olist_cell.sv
rtl/olist_chain.sv
rtl/ordered_item_list_core.sv
tb/sv/olist_tb_pkg.sv
tb/sv/tb.sv
